### src/fdtss_pkg.sv
package fdtss_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxDepthDefault  = 255;
  localparam int unsigned IndexBitsDefault = 16;

  // Field widths.
  localparam int unsigned WordW  = 32;
  localparam int unsigned KindW  = 4;
  localparam int unsigned DepthW = 8;
  localparam int unsigned IndexW = 16;
  localparam int unsigned LeftW  = 30;

  // Structure block token codes.
  localparam logic [WordW-1:0] TokBeginNode = 32'h0000_0001;
  localparam logic [WordW-1:0] TokEndNode   = 32'h0000_0002;
  localparam logic [WordW-1:0] TokProp      = 32'h0000_0003;
  localparam logic [WordW-1:0] TokNop       = 32'h0000_0004;
  localparam logic [WordW-1:0] TokEnd       = 32'h0000_0009;

  // Word classes reported in the kind field.
  typedef enum logic [KindW-1:0] {
    KindBegin    = 4'd0,
    KindName     = 4'd1,
    KindNameEnd  = 4'd2,
    KindEndNode  = 4'd3,
    KindProp     = 4'd4,
    KindLen      = 4'd5,
    KindNameOff  = 4'd6,
    KindData     = 4'd7,
    KindNop      = 4'd8,
    KindEnd      = 4'd9,
    KindUnknown  = 4'd10,
    KindAfterEnd = 4'd11
  } kind_e;

  // Scanner phase, one-hot.
  typedef enum logic [4:0] {
    PhToken   = 5'b00001,
    PhName    = 5'b00010,
    PhLen     = 5'b00100,
    PhNameOff = 5'b01000,
    PhData    = 5'b10000
  } phase_e;

  // One classified word.
  typedef struct packed {
    kind_e             kind;
    logic [DepthW-1:0] depth;
    logic [WordW-1:0]  value;
    logic [IndexW-1:0] word_index;
    logic              group_last;
    logic              depth_error;
  } result_t;

  // Width of the packed output data bus: kind, depth, value, word_index.
  localparam int unsigned OutDataW = 64;

endpackage

### src/fdtss_core.sv
module fdtss_core
  import fdtss_pkg::*;
#(
  parameter int unsigned MAX_DEPTH  = MaxDepthDefault,
  parameter int unsigned INDEX_BITS = IndexBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [WordW-1:0] word_i,
  input  logic             first_i,
  output result_t          res_o
);

  localparam logic [DepthW-1:0] DepthLimit =
      (MAX_DEPTH > 255) ? 8'd255 : DepthW'(MAX_DEPTH);
  localparam logic [63:0] IdxFull = (64'd1 << INDEX_BITS) - 64'd1;
  localparam logic [IndexW-1:0] IdxLimit =
      (INDEX_BITS >= IndexW) ? {IndexW{1'b1}} : IdxFull[IndexW-1:0];

  phase_e            phase_q, phase_d;
  logic [LeftW-1:0]  left_q, left_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [IndexW-1:0] count_q, count_d;
  logic              fin_q, fin_d;

  phase_e            phase_c;
  logic [LeftW-1:0]  left_c;
  logic [DepthW-1:0] depth_c;
  logic [IndexW-1:0] idx_c;
  logic              fin_c;
  logic              zero_byte;
  logic [WordW:0]    len_sum;
  logic [LeftW-1:0]  left_dec;

  assign zero_byte = (word_i[31:24] == 8'd0) || (word_i[23:16] == 8'd0) ||
                     (word_i[15:8] == 8'd0) || (word_i[7:0] == 8'd0);
  assign len_sum   = {1'b0, word_i} + 33'd3;

  always_comb begin
    // A word marked first sees the state as it is after reset.
    phase_c = first_i ? PhToken : phase_q;
    left_c  = first_i ? '0 : left_q;
    depth_c = first_i ? '0 : depth_q;
    idx_c   = first_i ? '0 : count_q;
    fin_c   = first_i ? 1'b0 : fin_q;

    left_dec = (left_c != '0) ? left_c - LeftW'(1) : left_c;

    phase_d = phase_c;
    left_d  = left_c;
    depth_d = depth_c;
    fin_d   = fin_c;
    count_d = (idx_c < IdxLimit) ? idx_c + IndexW'(1) : idx_c;

    res_o.kind        = KindUnknown;
    res_o.group_last  = 1'b0;
    res_o.depth_error = 1'b0;

    if (fin_c) begin
      res_o.kind = KindAfterEnd;
    end else begin
      case (phase_c)
        PhName: begin
          if (zero_byte) begin
            res_o.kind       = KindNameEnd;
            res_o.group_last = 1'b1;
            phase_d          = PhToken;
          end else begin
            res_o.kind = KindName;
          end
        end
        PhLen: begin
          res_o.kind = KindLen;
          left_d     = len_sum[31:2];
          phase_d    = PhNameOff;
        end
        PhNameOff: begin
          res_o.kind = KindNameOff;
          phase_d    = (left_c != '0) ? PhData : PhToken;
        end
        PhData: begin
          res_o.kind = KindData;
          left_d     = left_dec;
          if (left_dec == '0) begin
            res_o.group_last = 1'b1;
            phase_d          = PhToken;
          end
        end
        default: begin
          phase_d = PhToken;
          if (word_i == TokBeginNode) begin
            res_o.kind = KindBegin;
            if (depth_c >= DepthLimit) begin
              res_o.depth_error = 1'b1;
            end else begin
              depth_d = depth_c + DepthW'(1);
            end
            phase_d = PhName;
          end else if (word_i == TokEndNode) begin
            res_o.kind = KindEndNode;
            if (depth_c == '0) begin
              res_o.depth_error = 1'b1;
            end else begin
              depth_d = depth_c - DepthW'(1);
            end
          end else if (word_i == TokProp) begin
            res_o.kind = KindProp;
            phase_d    = PhLen;
          end else if (word_i == TokNop) begin
            res_o.kind = KindNop;
          end else if (word_i == TokEnd) begin
            res_o.kind = KindEnd;
            fin_d      = 1'b1;
          end else begin
            res_o.kind = KindUnknown;
          end
        end
      endcase
    end

    res_o.depth      = depth_d;
    res_o.value      = word_i;
    res_o.word_index = idx_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhToken;
      left_q  <= '0;
      depth_q <= '0;
      count_q <= '0;
      fin_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      depth_q <= depth_d;
      count_q <= count_d;
      fin_q   <= fin_d;
    end
  end

endmodule

### src/fdtss_out_reg.sv
module fdtss_out_reg
  import fdtss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  result_t res_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // The register takes a new result when empty or when its result leaves.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### src/fdt_structure_token_scanner_unit.sv
// Flattened devicetree structure block scanner. Feed the structure block one
// 32-bit big-endian word per item on the slave stream, with tuser high on the
// first word of a block; that word restarts the scanner. Each item gives
// exactly one result item on the master stream: the word's class, the node
// depth after it, the word itself, its position in the block and an error
// flag for depth underflow or overflow. The block sustains one item per
// clock cycle while the master stream does not stall. An item is held in
// the input register and then in the result register, from which its
// result item is offered on the master stream. The classify-and-update
// logic between the two registers is combinational and feeds its own
// state registers. Depth saturates at the smaller of MAX_DEPTH and 255, and
// the word index saturates at the smaller of 2^INDEX_BITS - 1 and 65535.
module fdt_structure_token_scanner_unit
  import fdtss_pkg::*;
#(
  parameter int unsigned MAX_DEPTH  = MaxDepthDefault,
  parameter int unsigned INDEX_BITS = IndexBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WordW-1:0]    s_axis_tdata,   // word[31:0]
  input  logic                s_axis_tuser,   // first
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // kind[3:0], depth[11:4],
                                              // value[43:12],
                                              // word_index[59:44], zeros
  output logic                m_axis_tlast,   // group_last
  output logic                m_axis_tuser    // depth_error
);

  // Input register stage.
  logic             in_valid_q;
  logic [WordW-1:0] in_word_q;
  logic             in_first_q;
  logic             stage_ready;
  logic             advance;

  result_t core_res;
  result_t out_res;

  // The input register moves on whenever the result register can take its
  // item, so a new item is accepted every cycle while the output flows.
  assign advance       = in_valid_q && stage_ready;
  assign s_axis_tready = !in_valid_q || stage_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
  end

  // Classification and scanner state; the state advances with each item
  // that moves into the result register.
  fdtss_core #(
    .MAX_DEPTH (MAX_DEPTH),
    .INDEX_BITS(INDEX_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .word_i (in_word_q),
    .first_i(in_first_q),
    .res_o  (core_res)
  );

  // Result register; it holds a result while the consumer stalls.
  fdtss_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_q),
    .ready_o(stage_ready),
    .res_i  (core_res),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.word_index, out_res.value, out_res.depth,
                         out_res.kind};
  assign m_axis_tlast = out_res.group_last;
  assign m_axis_tuser = out_res.depth_error;

  // A depth error only comes from a begin-node or an end-node token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (out_res.kind == KindBegin || out_res.kind == KindEndNode))
    else $error("depth error on a word that is no node token");

  // The group end mark only comes on the last name word or data word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (out_res.kind == KindNameEnd || out_res.kind == KindData))
    else $error("group end on a word that ends no group");

  // An item held in the input register is not lost while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !stage_ready) |=> (in_valid_q && $stable(in_word_q)))
    else $error("input register dropped a stalled item");

  // The reported depth never passes the depth limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ({24'd0, out_res.depth} <= ((MAX_DEPTH > 255) ? 32'd255 : 32'(MAX_DEPTH))))
    else $error("depth beyond its limit");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

// Testbench for the devicetree structure block scanner. Items go in on the
// slave stream, and every accepted item is classified by a small predictor
// inside the scoreboard. Each result item from the master stream is then
// checked field by field against the oldest expected result.
module tb;
  import fdtss_pkg::*;

  localparam int unsigned DepthMax   = MaxDepthDefault;
  localparam int unsigned IndexBits  = IndexBitsDefault;
  localparam int unsigned DepthLimit = (DepthMax > 255) ? 255 : DepthMax;
  localparam int unsigned IndexLimit = (IndexBits >= 16) ? 65535 : ((1 << IndexBits) - 1);
  // Cycles in which no item moves on either stream before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  // Lower bound on the number of random items after the directed part.
  localparam int unsigned RandomItems = 900;

  // Scoreboard: predicts the class of every accepted word and holds the
  // expected result items until the block delivers them.
  class fdt_scoreboard;
    localparam int unsigned DepthLo = KindW;
    localparam int unsigned ValueLo = DepthLo + DepthW;
    localparam int unsigned IndexLo = ValueLo + WordW;
    localparam int unsigned PadLo   = IndexLo + IndexW;

    result_t           expected_q[$];
    phase_e            scan_phase;
    logic [LeftW-1:0]  words_left;
    logic [DepthW-1:0] nest_depth;
    logic [IndexW-1:0] word_count;
    bit                seen_end;
    int unsigned       depth_lim;
    int unsigned       index_lim;
    int unsigned       errors;

    function new(int unsigned dlim, int unsigned ilim);
      depth_lim = dlim;
      index_lim = ilim;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      scan_phase = PhToken;
      words_left = '0;
      nest_depth = '0;
      word_count = '0;
      seen_end   = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Classifies one accepted word and queues its expected result.
    function void note_word(logic [WordW-1:0] w, logic first);
      result_t    r;
      logic [WordW:0] len_words;
      if (first) restart();
      r.kind        = KindUnknown;
      r.value       = w;
      r.word_index  = word_count;
      r.group_last  = 1'b0;
      r.depth_error = 1'b0;
      if (word_count < index_lim) word_count++;
      if (seen_end) begin
        r.kind = KindAfterEnd;
      end else begin
        case (scan_phase)
          PhName: begin
            if (w[31:24] == 8'h00 || w[23:16] == 8'h00 ||
                w[15:8] == 8'h00 || w[7:0] == 8'h00) begin
              r.kind       = KindNameEnd;
              r.group_last = 1'b1;
              scan_phase   = PhToken;
            end else begin
              r.kind = KindName;
            end
          end
          PhLen: begin
            // Round the byte count up to words; only the low bits are kept.
            len_words  = ({1'b0, w} + 33'd3) >> 2;
            words_left = len_words[LeftW-1:0];
            r.kind     = KindLen;
            scan_phase = PhNameOff;
          end
          PhNameOff: begin
            r.kind     = KindNameOff;
            scan_phase = (words_left != '0) ? PhData : PhToken;
          end
          PhData: begin
            r.kind = KindData;
            if (words_left != '0) words_left--;
            if (words_left == '0) begin
              r.group_last = 1'b1;
              scan_phase   = PhToken;
            end
          end
          default: begin
            scan_phase = PhToken;
            if (w == TokBeginNode) begin
              r.kind = KindBegin;
              if (nest_depth >= depth_lim) r.depth_error = 1'b1;
              else nest_depth++;
              scan_phase = PhName;
            end else if (w == TokEndNode) begin
              r.kind = KindEndNode;
              if (nest_depth == '0) r.depth_error = 1'b1;
              else nest_depth--;
            end else if (w == TokProp) begin
              r.kind     = KindProp;
              scan_phase = PhLen;
            end else if (w == TokNop) begin
              r.kind = KindNop;
            end else if (w == TokEnd) begin
              r.kind   = KindEnd;
              seen_end = 1'b1;
            end
          end
        endcase
      end
      r.depth = nest_depth;
      expected_q.push_back(r);
    endfunction

    // Only the first hundred mismatches are printed; all are counted.
    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR: %s", msg);
    endtask

    task check_result(logic [OutDataW-1:0] data, logic last, logic derr);
      result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result item with nothing expected, tdata %h", data));
        return;
      end
      e = expected_q.pop_front();
      if (data[KindW-1:0] !== e.kind)
        report($sformatf("word %0d: kind %0d, expected %0d",
                         e.word_index, data[KindW-1:0], e.kind));
      if (data[DepthLo +: DepthW] !== e.depth)
        report($sformatf("word %0d: depth %0d, expected %0d",
                         e.word_index, data[DepthLo +: DepthW], e.depth));
      if (data[ValueLo +: WordW] !== e.value)
        report($sformatf("word %0d: value %h, expected %h",
                         e.word_index, data[ValueLo +: WordW], e.value));
      if (data[IndexLo +: IndexW] !== e.word_index)
        report($sformatf("word index %0d, expected %0d",
                         data[IndexLo +: IndexW], e.word_index));
      if (data[OutDataW-1:PadLo] !== '0)
        report($sformatf("word %0d: padding bits %h not zero",
                         e.word_index, data[OutDataW-1:PadLo]));
      if (last !== e.group_last)
        report($sformatf("word %0d: tlast %b, expected %b",
                         e.word_index, last, e.group_last));
      if (derr !== e.depth_error)
        report($sformatf("word %0d: depth error %b, expected %b",
                         e.word_index, derr, e.depth_error));
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [WordW-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  fdt_scoreboard sb;
  // When set, neither side idles; used for one long stretch of the run.
  bit          quiet     = 1'b0;
  // Marks the next word sent as the first word of a structure block.
  bit          start_blk = 1'b0;
  int unsigned sent_cnt  = 0;
  int unsigned idle_cycles = 0;

  fdt_structure_token_scanner_unit #(
    .MAX_DEPTH (DepthMax),
    .INDEX_BITS(IndexBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // word[31:0]
    .s_axis_tuser (s_axis_tuser),   // first
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // kind[3:0], depth[11:4], value[43:12],
                                    // word_index[59:44], zeros
    .m_axis_tlast (m_axis_tlast),   // group_last
    .m_axis_tuser (m_axis_tuser)    // depth_error
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls in about one cycle of five, except in quiet stretches.
  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 20);
  end

  // Both monitors sample at the rising edge, before any driven value moves.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata, s_axis_tuser);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // The watchdog ends a hung run: it counts cycles in which no item moves
  // on either stream.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Sends one word, after a random number of idle cycles, and returns once
  // it has been accepted. Valid stays high so back-to-back items have no gap.
  task automatic send_word(input logic [WordW-1:0] w);
    while (!quiet && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= start_blk;
    start_blk = 1'b0;
    sent_cnt++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the sender back until every expected result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // A name word built from nonzero bytes. A terminating word gets at least
  // one zero byte, in a random position, and sometimes more.
  function automatic logic [WordW-1:0] name_word(bit terminate);
    logic [WordW-1:0] w;
    int unsigned      zpos;
    for (int b = 0; b < 4; b++) w[8*b +: 8] = 8'($urandom_range(1, 255));
    if (terminate) begin
      zpos = $urandom_range(3);
      w[8*zpos +: 8] = 8'h00;
      for (int b = 0; b < 4; b++) if ($urandom_range(3) == 0) w[8*b +: 8] = 8'h00;
    end
    return w;
  endfunction

  task automatic send_name();
    repeat ($urandom_range(0, 3)) send_word(name_word(1'b0));
    send_word(name_word(1'b1));
  endtask

  // Sends a property with its data words, but at most max_data of them.
  task automatic send_prop(input logic [WordW-1:0] len, input int unsigned max_data);
    logic [63:0] n_words;
    n_words = (({32'b0, len} + 64'd3) >> 2) & 64'h3FFF_FFFF;
    send_word(TokProp);
    send_word(len);
    send_word($urandom);
    for (longint unsigned i = 0; i < n_words && i < max_data; i++) send_word($urandom);
  endtask

  // One structure block: mostly a well-formed tree with random content,
  // mixed with stray words, depth underflow, restarts and cut-off blocks.
  task automatic gen_block();
    int unsigned      depth_t;
    int unsigned      pick;
    logic [WordW-1:0] len;
    depth_t   = 0;
    start_blk = 1'b1;
    repeat ($urandom_range(4, 40)) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        if (depth_t < 8) begin
          send_word(TokBeginNode);
          send_name();
          depth_t++;
        end else begin
          send_word(TokNop);
        end
      end else if (pick < 45) begin
        if (depth_t > 0) begin
          send_word(TokEndNode);
          depth_t--;
        end else begin
          send_word(TokNop);
        end
      end else if (pick < 80) begin
        case ($urandom_range(9))
          7: send_prop(32'($urandom_range(13, 40)), 16);
          // Lengths this close to the top round up to zero data words.
          8: send_prop(32'hFFFF_FFFC + 32'($urandom_range(1, 3)), 16);
          9: begin
            // A long property cut short; the next block restarts the scanner.
            send_prop($urandom, 3);
            return;
          end
          default: send_prop(32'($urandom_range(0, 12)), 16);
        endcase
      end else if (pick < 88) begin
        send_word(TokNop);
      end else begin
        case ($urandom_range(5))
          0: send_word($urandom);
          1: send_word(32'($urandom_range(0, 15)));
          2: begin
            send_word(TokEndNode);
            if (depth_t > 0) depth_t--;
          end
          3: begin
            // Restart in the middle of a block.
            start_blk = 1'b1;
            depth_t   = 0;
          end
          4: return;
          default: begin
            // A node whose name is never finished.
            send_word(TokBeginNode);
            return;
          end
        endcase
      end
    end
    repeat (depth_t) send_word(TokEndNode);
    send_word(TokEnd);
    repeat ($urandom_range(0, 3)) send_word($urandom);
  endtask

  initial begin
    bit drained;
    sb = new(DepthLimit, IndexLimit);
    drained = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every class of word, an empty property, data words at
    // the extremes, depth underflow, lengths that round to zero data words,
    // words after the end token and restarts in mid-block.
    start_blk = 1'b1;
    send_word(TokBeginNode);
    send_word(32'h6162_6364);
    send_word(32'h6566_0000);
    send_word(TokProp);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(TokProp);
    send_word(32'h0000_0005);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(TokNop);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(TokEndNode);
    send_word(TokEndNode);
    send_word(TokProp);
    send_word(32'hFFFF_FFFF);
    send_word(32'h1234_5678);
    send_word(TokEnd);
    send_word(TokBeginNode);
    send_word(32'hFFFF_FFFF);
    start_blk = 1'b1;
    send_word(TokProp);
    send_word(32'h7FFF_FFFF);
    start_blk = 1'b1;
    send_word(TokBeginNode);

    // Random part. One stretch runs without idling on either side, and once
    // the sender holds off until the block has nothing left in flight.
    while (sent_cnt < 26 + RandomItems) begin
      quiet = (sent_cnt >= 400 && sent_cnt < 700);
      if (!drained && sent_cnt >= 300) begin
        wait_drained();
        drained = 1'b1;
      end
      gen_block();
    end
    quiet = 1'b0;

    // Depth overflow: nest one level past the limit, then unwind a little.
    start_blk = 1'b1;
    repeat (DepthLimit + 1) begin
      send_word(TokBeginNode);
      send_word(name_word(1'b1));
    end
    repeat (3) send_word(TokEndNode);
    send_word(TokEnd);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
